FILE: rtl/core/addressed_packet_receiver_top_defines.svh
// Assertion macros for the addressed packet receiver.
// Included by the top level; depends on a clock named clk and a reset named rst.
`ifndef ADDRESSED_PACKET_RECEIVER_TOP_DEFINES_SVH
`define ADDRESSED_PACKET_RECEIVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define APR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define APR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define APR_ASSERT_SAME(lbl, ante, cons, msg)
`define APR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/apr_pkg.sv
// Shared types and constants for the addressed packet receiver.
// No dependencies; used by the top level, apr_fsm and apr_out_reg.
package apr_pkg;

  localparam logic [7:0] HEADER_BYTE    = 8'hAA;
  localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

  localparam logic [1:0] CFG_OWN_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_GROUP_ADDR   = 2'd1;
  localparam logic [1:0] CFG_GROUP_LEADER = 2'd2;

  localparam logic [7:0] OWN_ADDRESS_RESET = 8'd1;
  localparam logic [7:0] GROUP_ADDR_RESET  = 8'd128;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CMD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CKSUM = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] group_addr;
    logic       is_group_leader;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] command;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic [3:0] payload_length;
    logic       checksum_error;
    logic       execute;
    logic       respond;
  } result_t;

endpackage

FILE: rtl/core/addressed_packet_receiver_top.sv
// Top level of the addressed packet receiver: configuration registers and stages.
// Depends on apr_pkg, apr_in_reg, apr_fsm, apr_out_reg and the assertion header.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  kind, command, byte_index, byte_value,
//                                    payload_length, checksum_error, execute, respond
//   config    cfg_we                 cfg_index, cfg_data
//
// A byte is registered in the input register on acceptance, then parsed, and its result
// is registered in the result register; one byte is taken per cycle unless the output stalls.
// The input register and the result register let a new byte in while a result waits.
// Reset is synchronous and returns the parser to the header hunt with default addresses.
// A stalled output holds the parser; the input stage then fills and drops in_ready.
`include "addressed_packet_receiver_top_defines.svh"
module addressed_packet_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [3:0] command,
  output logic [3:0] byte_index,
  output logic [7:0] byte_value,
  output logic [3:0] payload_length,
  output logic       checksum_error,
  output logic       execute,
  output logic       respond,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  import apr_pkg::*;

  cfg_t       cfg;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address     <= OWN_ADDRESS_RESET;
      cfg.group_addr      <= GROUP_ADDR_RESET;
      cfg.is_group_leader <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:  cfg.own_address     <= cfg_data;
        CFG_GROUP_ADDR:   cfg.group_addr      <= cfg_data;
        CFG_GROUP_LEADER: cfg.is_group_leader <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign step = byte_valid && (!out_valid || out_ready);

  apr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (step)
  );

  apr_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_data (byte_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  apr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind           = out_res.kind;
  assign command        = out_res.command;
  assign byte_index     = out_res.byte_index;
  assign byte_value     = out_res.byte_value;
  assign payload_length = out_res.payload_length;
  assign checksum_error = out_res.checksum_error;
  assign execute        = out_res.execute;
  assign respond        = out_res.respond;

  `APR_ASSERT_SAME(a_end_zero_payload, out_valid && kind == KIND_END, byte_value == 8'd0 && byte_index == 4'd0, "End transaction carries payload fields.")
  `APR_ASSERT_SAME(a_exec_needs_good_sum, out_valid && execute, kind == KIND_END && !checksum_error, "Execute given with a bad checksum.")
  `APR_ASSERT_SAME(a_index_in_range, out_valid && kind == KIND_DATA, byte_index < payload_length, "Data index beyond payload length.")
  `APR_ASSERT_NEXT(a_step_without_result, step && !res_valid, !out_valid, "Result register valid after a step with no result.")

endmodule

FILE: rtl/core/apr_in_reg.sv
// Input register stage: holds one received byte until the parser takes it.
// Depends on nothing but the handshake signals of the input channel.
module apr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  output logic [7:0] byte_data,
  input  logic       byte_take
);

  assign in_ready = !byte_valid || byte_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (byte_take) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_data <= rx_byte;
    end
  end

endmodule

FILE: rtl/core/apr_fsm.sv
// Packet parser: header hunt, address, command, payload and checksum phases.
// Depends on apr_pkg for the phase type, configuration and result structs.
module apr_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_data,
  input  apr_pkg::cfg_t    cfg,
  output logic             res_valid,
  output apr_pkg::result_t res
);

  import apr_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [3:0] bytes_seen;
  logic [3:0] bytes_seen_next;
  logic [3:0] bytes_expected;
  logic [3:0] bytes_expected_next;
  logic [7:0] packet_address;
  logic [7:0] packet_address_next;
  logic [3:0] command_nibble;
  logic [3:0] command_nibble_next;
  logic       own_hit;
  logic       group_hit;
  logic       sum_bad;

  always_comb begin
    phase_next          = phase;
    running_sum_next    = running_sum;
    bytes_seen_next     = bytes_seen;
    bytes_expected_next = bytes_expected;
    packet_address_next = packet_address;
    command_nibble_next = command_nibble;
    unique case (phase)
      PH_ADDR: begin
        packet_address_next = byte_data;
        running_sum_next    = byte_data;
        phase_next          = PH_CMD;
      end
      PH_CMD: begin
        command_nibble_next = byte_data[3:0];
        bytes_expected_next = byte_data[7:4];
        running_sum_next    = running_sum + byte_data;
        bytes_seen_next     = 4'd0;
        phase_next          = (byte_data[7:4] != 4'd0) ? PH_DATA : PH_CKSUM;
      end
      PH_DATA: begin
        running_sum_next = running_sum + byte_data;
        bytes_seen_next  = bytes_seen + 4'd1;
        if (bytes_seen_next == bytes_expected) begin
          phase_next = PH_CKSUM;
        end
      end
      PH_CKSUM: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (byte_data == HEADER_BYTE) ? PH_ADDR : PH_HUNT;
      end
    endcase
  end

  assign own_hit   = (packet_address == cfg.own_address);
  assign group_hit = (packet_address == cfg.group_addr);
  assign sum_bad   = (byte_data != running_sum);

  always_comb begin
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.command        = command_nibble;
    res.byte_index     = 4'd0;
    res.byte_value     = 8'd0;
    res.payload_length = bytes_expected;
    res.checksum_error = 1'b0;
    res.execute        = 1'b0;
    res.respond        = 1'b0;
    unique case (phase)
      PH_DATA: begin
        res_valid      = 1'b1;
        res.byte_index = bytes_seen;
        res.byte_value = byte_data;
      end
      PH_CKSUM: begin
        res_valid          = 1'b1;
        res.kind           = KIND_END;
        res.checksum_error = sum_bad;
        res.execute        = !sum_bad
                             && (own_hit || group_hit || packet_address == BROADCAST_ADDR);
        res.respond        = own_hit || (group_hit && cfg.is_group_leader);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      running_sum    <= 8'd0;
      bytes_seen     <= 4'd0;
      bytes_expected <= 4'd0;
      packet_address <= 8'd0;
      command_nibble <= 4'd0;
    end else if (step) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      bytes_seen     <= bytes_seen_next;
      bytes_expected <= bytes_expected_next;
      packet_address <= packet_address_next;
      command_nibble <= command_nibble_next;
    end
  end

endmodule

FILE: rtl/core/apr_out_reg.sv
// Result register: holds one result transaction until the consumer takes it.
// Depends on apr_pkg for the result struct.
module apr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             res_valid,
  input  apr_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output apr_pkg::result_t out_res
);

  import apr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_res <= res;
    end
  end

endmodule
